// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CFMA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CFMA_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/cfma_pkg.sv -----
// shared types and constants of the console fifo merger
`timescale 1ns / 1ps

package cfma_pkg;

  // default sizes
  localparam int BUF_DEPTH_DEF = 64;
  localparam int NUM_BUFS_DEF  = 4;

  // character handling
  localparam int          CHAR_W     = 8;
  localparam logic [7:0]  CTRL_LIMIT = 8'h20;
  localparam logic [7:0]  CHAR_NUL   = 8'h00;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SCAN  = 1'b1;

  // one input word
  typedef struct packed {
    logic              command;
    logic [1:0]        buffer_index;
    logic [CHAR_W-1:0] char_in;
    logic              tx_ready;
  } in_item_t;

  // one result word
  typedef struct packed {
    logic              write_ok;
    logic              send_valid;
    logic [CHAR_W-1:0] send_char;
    logic [1:0]        sent_from;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_pending;
  } dp_stat_t;

endpackage

// ----- rtl/cfma_ram.sv -----
// generic single-port ram with registered read
`timescale 1ns / 1ps

module cfma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/cfma_ctrl.sv -----
// sequencing controller of the console fifo merger
`timescale 1ns / 1ps

module cfma_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  cfma_pkg::dp_stat_t   stat_i,
  output cfma_pkg::ctrl_cmd_t  cmd_o,
  output logic                 res_valid_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  // a new word may enter while the previous result is shown
  assign busy   = (state_q == ST_EXEC) || (state_q == ST_READ);
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = stat_i.pop_pending ? ST_READ : ST_RESP;
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commands to the datapath
  assign cmd_o.capture = accept;
  assign cmd_o.exec    = (state_q == ST_EXEC);
  assign cmd_o.finish  = (state_q == ST_READ);
  assign res_valid_o   = (state_q == ST_RESP);

endmodule

// ----- rtl/cfma_dp.sv -----
// datapath: fifo pointers, round-robin choice, message lock and result word
`timescale 1ns / 1ps

module cfma_dp #(
  parameter int BUF_DEPTH = cfma_pkg::BUF_DEPTH_DEF,
  parameter int NUM_BUFS  = cfma_pkg::NUM_BUFS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfma_pkg::in_item_t   item_i,
  input  cfma_pkg::ctrl_cmd_t  cmd_i,
  output cfma_pkg::dp_stat_t   stat_o,
  output cfma_pkg::out_item_t  res_o
);

  localparam int PTR_W  = $clog2(BUF_DEPTH);
  localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int BUF_W  = $clog2(NUM_BUFS);
  localparam int ADDR_W = $clog2(NUM_BUFS * BUF_DEPTH);

  cfma_pkg::in_item_t  item_q;
  cfma_pkg::out_item_t res_q;

  logic [PTR_W-1:0] rptr_q [NUM_BUFS];
  logic [PTR_W-1:0] wptr_q [NUM_BUFS];
  logic [CNT_W-1:0] fill_q [NUM_BUFS];
  logic [BUF_W-1:0] scan_q;
  logic             locked_q;
  logic [BUF_W-1:0] lock_buf_q;
  logic [BUF_W-1:0] from_q;

  logic [NUM_BUFS-1:0] nonempty;
  logic                rr_found;
  logic [BUF_W-1:0]    rr_buf;
  logic                is_write, scan_go, widx_ok, wr_ok, pop_found;
  logic [BUF_W-1:0]    wbuf, pop_buf, sel;
  logic [PTR_W-1:0]    ptr_sel, ptr_next;
  logic [ADDR_W-1:0]   ram_addr;
  logic [cfma_pkg::CHAR_W-1:0] rd_char;

  // occupancy flags
  always_comb begin
    for (int j = 0; j < NUM_BUFS; j++) begin
      nonempty[j] = (fill_q[j] != '0);
    end
  end

  // rotating priority search, starting after the last buffer served
  always_comb begin : rr_search
    logic [BUF_W:0] sum;
    rr_found = 1'b0;
    rr_buf   = '0;
    sum      = '0;
    for (int k = NUM_BUFS; k >= 1; k--) begin
      sum = {1'b0, scan_q} + (BUF_W+1)'(k);
      if (sum >= (BUF_W+1)'(NUM_BUFS)) sum = sum - (BUF_W+1)'(NUM_BUFS);
      if (nonempty[BUF_W'(sum)]) begin
        rr_found = 1'b1;
        rr_buf   = BUF_W'(sum);
      end
    end
  end

  // decode of the held word
  assign is_write  = (item_q.command == cfma_pkg::CMD_WRITE);
  assign scan_go   = (item_q.command == cfma_pkg::CMD_SCAN) && item_q.tx_ready;
  assign widx_ok   = (32'(item_q.buffer_index) < NUM_BUFS);
  assign wbuf      = BUF_W'(item_q.buffer_index);
  assign pop_buf   = locked_q ? lock_buf_q : rr_buf;
  assign pop_found = scan_go && (locked_q ? nonempty[lock_buf_q] : rr_found);
  assign sel       = is_write ? wbuf : pop_buf;
  assign wr_ok     = is_write && widx_ok && (fill_q[sel] != CNT_W'(BUF_DEPTH));

  // pointer of the selected buffer and its wrapped successor
  assign ptr_sel  = is_write ? wptr_q[sel] : rptr_q[sel];
  assign ptr_next = (ptr_sel == PTR_W'(BUF_DEPTH - 1)) ? '0 : ptr_sel + PTR_W'(1);
  assign ram_addr = ADDR_W'(sel) * ADDR_W'(BUF_DEPTH) + ADDR_W'(ptr_sel);

  assign stat_o.pop_pending = pop_found;

  // character store
  cfma_ram #(
    .WIDTH (cfma_pkg::CHAR_W),
    .DEPTH (NUM_BUFS * BUF_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && wr_ok),
    .re_i    (cmd_i.exec && pop_found),
    .addr_i  (ram_addr),
    .wdata_i (item_q.char_in),
    .rdata_o (rd_char)
  );

  // fifo pointers and fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_BUFS; j++) begin
        rptr_q[j] <= '0;
        wptr_q[j] <= '0;
        fill_q[j] <= '0;
      end
    end else if (cmd_i.exec) begin
      for (int j = 0; j < NUM_BUFS; j++) begin
        if (sel == BUF_W'(j)) begin
          if (wr_ok) begin
            wptr_q[j] <= ptr_next;
            fill_q[j] <= fill_q[j] + CNT_W'(1);
          end else if (pop_found) begin
            rptr_q[j] <= ptr_next;
            fill_q[j] <= fill_q[j] - CNT_W'(1);
          end
        end
      end
    end
  end

  // round-robin position and message lock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= BUF_W'(NUM_BUFS - 1);
      locked_q   <= 1'b0;
      lock_buf_q <= '0;
    end else if (cmd_i.exec) begin
      if (pop_found && !locked_q) scan_q <= pop_buf;
    end else if (cmd_i.finish) begin
      if (!locked_q && (rd_char >= cfma_pkg::CTRL_LIMIT)) begin
        locked_q   <= 1'b1;
        lock_buf_q <= from_q;
      end else if (locked_q && (rd_char < cfma_pkg::CTRL_LIMIT)) begin
        locked_q <= 1'b0;
      end
    end
  end

  // held word, source buffer and result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      from_q           <= pop_buf;
      res_q.write_ok   <= wr_ok;
      res_q.send_valid <= 1'b0;
      res_q.send_char  <= cfma_pkg::CHAR_NUL;
      res_q.sent_from  <= 2'b00;
    end else if (cmd_i.finish) begin
      res_q.write_ok   <= 1'b0;
      res_q.send_valid <= (rd_char != cfma_pkg::CHAR_NUL);
      res_q.send_char  <= rd_char;
      res_q.sent_from  <= 2'(from_q);
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/console_fifo_mux_arbiter_core.sv -----
// top level of the console fifo merger
`timescale 1ns / 1ps

// Keeps NUM_BUFS byte fifos of BUF_DEPTH entries and merges them onto one
// console output. A word is taken at a clock edge with start high and busy
// low; its result appears on res_o for exactly one cycle with res_valid_o
// high, and the receiver cannot stall it. A write, or a scan that dequeues
// nothing, goes through states EXEC and RESP; a scan dequeuing a character
// also visits READ, the registered read of the shared character store. The
// next word may be taken in the cycle its predecessor's result is shown.
// Scans pick fifos round-robin starting after the last one served; a
// printable character locks onto its fifo until a control character
// arrives from it, and NUL is dequeued but not sent. A full fifo rejects a
// write with write_ok low. The store needs no clearing after reset.
module console_fifo_mux_arbiter_core #(
  parameter int BUF_DEPTH = cfma_pkg::BUF_DEPTH_DEF,
  parameter int NUM_BUFS  = cfma_pkg::NUM_BUFS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  cfma_pkg::in_item_t   item_i,
  output logic                 res_valid_o,
  output cfma_pkg::out_item_t  res_o
);

  cfma_pkg::ctrl_cmd_t cmd;
  cfma_pkg::dp_stat_t  stat;

  // sequencing
  cfma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .res_valid_o (res_valid_o)
  );

  // fifos, arbitration and result
  cfma_dp #(
    .BUF_DEPTH (BUF_DEPTH),
    .NUM_BUFS  (NUM_BUFS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res_o)
  );

endmodule

// ----- rtl/cfma_checker.sv -----
// port-level checks of the console fifo merger, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfma_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input cfma_pkg::in_item_t  item_i,
  input logic                res_valid_o,
  input cfma_pkg::out_item_t res_o
);

  // an accepted word keeps the block busy for the next cycle
  `CFMA_ASSERT(a_busy_after_accept, clk_i, rst_ni, (start && !busy) |=> busy, "no busy after accept")

  // result strobe lasts a single cycle
  `CFMA_ASSERT(a_strobe_single, clk_i, rst_ni, res_valid_o |=> !res_valid_o, "strobe held")

  // an accepted write reports in the RESP state right after its EXEC state
  `CFMA_ASSERT(a_write_timing, clk_i, rst_ni, (res_valid_o && res_o.write_ok) |-> ($past(start && !busy, 2) && ($past(item_i.command, 2) == cfma_pkg::CMD_WRITE)), "write_ok without write word")

  // a sent character follows a ready scan through the EXEC and READ states
  `CFMA_ASSERT(a_send_timing, clk_i, rst_ni, (res_valid_o && res_o.send_valid) |-> ($past(start && !busy, 3) && ($past(item_i.command, 3) == cfma_pkg::CMD_SCAN) && $past(item_i.tx_ready, 3)), "send without ready scan")

  // nul is never sent
  `CFMA_NEVER(a_no_nul_sent, clk_i, rst_ni, res_valid_o && res_o.send_valid && (res_o.send_char == cfma_pkg::CHAR_NUL), "nul sent")

endmodule

bind console_fifo_mux_arbiter_core cfma_checker u_checker (.*);
